// ----- rtl/segment_intersection_with_margin_defines.svh -----
// Assertion macros shared by the RTL.
`ifndef SEGMENT_INTERSECTION_WITH_MARGIN_DEFINES_SVH
`define SEGMENT_INTERSECTION_WITH_MARGIN_DEFINES_SVH

// Check cons in the same cycle as ante, outside reset.
`define SI_CHK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check cons in the cycle after ante, outside reset.
`define SI_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/si_pkg.sv -----
package si_pkg;
  localparam int COORD_BITS_DEF = 12;
  localparam int OUT_BITS = 14;
  localparam int MARGIN_BITS = 8;
  localparam logic [MARGIN_BITS-1:0] MARGIN_RESET = 8'd36;

  typedef struct packed {
    logic nz;
    logic negx;
    logic negy;
  } si_flags_t;
endpackage

// ----- rtl/si_ifs.sv -----
interface si_in_if #(parameter int CB = 12) ();
  logic          valid;
  logic          ready;
  logic [CB-1:0] seg1_start_x;
  logic [CB-1:0] seg1_start_y;
  logic [CB-1:0] seg1_end_x;
  logic [CB-1:0] seg1_end_y;
  logic [CB-1:0] seg2_start_x;
  logic [CB-1:0] seg2_start_y;
  logic [CB-1:0] seg2_end_x;
  logic [CB-1:0] seg2_end_y;

  modport source(output valid, seg1_start_x, seg1_start_y, seg1_end_x, seg1_end_y,
                 seg2_start_x, seg2_start_y, seg2_end_x, seg2_end_y, input ready);
  modport sink(input valid, seg1_start_x, seg1_start_y, seg1_end_x, seg1_end_y,
               seg2_start_x, seg2_start_y, seg2_end_x, seg2_end_y, output ready);
endinterface

interface si_out_if import si_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       hit;
  logic signed [OUT_BITS-1:0] cross_x;
  logic signed [OUT_BITS-1:0] cross_y;

  modport source(output valid, hit, cross_x, cross_y, input ready);
  modport sink(input valid, hit, cross_x, cross_y, output ready);
endinterface

// ----- rtl/si_coef.sv -----
module si_coef import si_pkg::*; #(
  parameter int N = COORD_BITS_DEF,
  localparam int NMW = 3*N+3,
  localparam int DMW = 2*N+3
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             vin,
  input  logic [N-1:0]     ax,
  input  logic [N-1:0]     ay,
  input  logic [N-1:0]     bx,
  input  logic [N-1:0]     by,
  input  logic [N-1:0]     cx,
  input  logic [N-1:0]     cy,
  input  logic [N-1:0]     dx,
  input  logic [N-1:0]     dy,
  output logic             vout,
  output logic [DMW-1:0]   den_mag,
  output logic [NMW-1:0]   nx_mag,
  output logic [NMW-1:0]   ny_mag,
  output si_flags_t        flags,
  output logic [8*N-1:0]   bounds
);
  logic [3:0] vld_r;

  // stage 1: line coefficients and boxes
  logic [2*N-1:0] pa, pb, pc, pd;
  logic signed [N:0] a1_r, b1_r, a2_r, b2_r;
  logic signed [2*N:0] c1_r, c2_r;
  logic [8*N-1:0] bnd1_r, bnd2_r, bnd3_r, bnd4_r, bnd_nxt;

  assign pa = ax * by;
  assign pb = bx * ay;
  assign pc = cx * dy;
  assign pd = dx * cy;

  always_comb begin
    bnd_nxt = '0;
    bnd_nxt[0*N +: N] = (ax < bx) ? ax : bx;
    bnd_nxt[1*N +: N] = (ax < bx) ? bx : ax;
    bnd_nxt[2*N +: N] = (cx < dx) ? cx : dx;
    bnd_nxt[3*N +: N] = (cx < dx) ? dx : cx;
    bnd_nxt[4*N +: N] = (ay < by) ? ay : by;
    bnd_nxt[5*N +: N] = (ay < by) ? by : ay;
    bnd_nxt[6*N +: N] = (cy < dy) ? cy : dy;
    bnd_nxt[7*N +: N] = (cy < dy) ? dy : cy;
  end

  // stage 2: cross products
  logic signed [2*N+1:0] pd1_r, pd2_r;
  logic signed [3*N+1:0] px1_r, px2_r, py1_r, py2_r;

  // stage 3: determinant and numerators
  logic signed [DMW-1:0] den_r;
  logic signed [NMW-1:0] nx_r, ny_r;

  // stage 4: magnitudes and signs
  logic [DMW-1:0] den_mag_r;
  logic [NMW-1:0] nx_mag_r, ny_mag_r;
  si_flags_t      flags_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], vin};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r   <= $signed({1'b0, ay}) - $signed({1'b0, by});
      b1_r   <= $signed({1'b0, bx}) - $signed({1'b0, ax});
      a2_r   <= $signed({1'b0, cy}) - $signed({1'b0, dy});
      b2_r   <= $signed({1'b0, dx}) - $signed({1'b0, cx});
      c1_r   <= $signed({1'b0, pa}) - $signed({1'b0, pb});
      c2_r   <= $signed({1'b0, pc}) - $signed({1'b0, pd});
      bnd1_r <= bnd_nxt;

      pd1_r  <= a1_r * b2_r;
      pd2_r  <= b1_r * a2_r;
      px1_r  <= c1_r * b2_r;
      px2_r  <= c2_r * b1_r;
      py1_r  <= c2_r * a1_r;
      py2_r  <= c1_r * a2_r;
      bnd2_r <= bnd1_r;

      den_r  <= pd1_r - pd2_r;
      nx_r   <= px2_r - px1_r;
      ny_r   <= py2_r - py1_r;
      bnd3_r <= bnd2_r;

      den_mag_r     <= den_r[DMW-1] ? DMW'(-den_r) : DMW'(den_r);
      nx_mag_r      <= nx_r[NMW-1] ? NMW'(-nx_r) : NMW'(nx_r);
      ny_mag_r      <= ny_r[NMW-1] ? NMW'(-ny_r) : NMW'(ny_r);
      flags_r.nz    <= den_r != '0;
      flags_r.negx  <= nx_r[NMW-1] ^ den_r[DMW-1];
      flags_r.negy  <= ny_r[NMW-1] ^ den_r[DMW-1];
      bnd4_r        <= bnd3_r;
    end
  end

  assign vout    = vld_r[3];
  assign den_mag = den_mag_r;
  assign nx_mag  = nx_mag_r;
  assign ny_mag  = ny_mag_r;
  assign flags   = flags_r;
  assign bounds  = bnd4_r;
endmodule

// ----- rtl/si_div_cell.sv -----
module si_div_cell import si_pkg::*; #(
  parameter int NMW = 39,
  parameter int DMW = 27,
  parameter int SW  = 99
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           vin,
  input  logic [DMW-1:0] d_in,
  input  logic [NMW-1:0] nx_in,
  input  logic [DMW-1:0] rx_in,
  input  logic [NMW-1:0] qx_in,
  input  logic [NMW-1:0] ny_in,
  input  logic [DMW-1:0] ry_in,
  input  logic [NMW-1:0] qy_in,
  input  logic [SW-1:0]  side_in,
  output logic           vout,
  output logic [DMW-1:0] d_out,
  output logic [NMW-1:0] nx_out,
  output logic [DMW-1:0] rx_out,
  output logic [NMW-1:0] qx_out,
  output logic [NMW-1:0] ny_out,
  output logic [DMW-1:0] ry_out,
  output logic [NMW-1:0] qy_out,
  output logic [SW-1:0]  side_out
);
  logic           vld_r;
  logic [DMW-1:0] d_r, rx_r, ry_r, rx_nxt, ry_nxt;
  logic [NMW-1:0] nx_r, ny_r, qx_r, qy_r;
  logic [SW-1:0]  side_r;
  logic [DMW:0]   trial_x, trial_y, diff_x, diff_y;
  logic           ge_x, ge_y;

  always_comb begin
    trial_x = {rx_in, nx_in[NMW-1]};
    trial_y = {ry_in, ny_in[NMW-1]};
    diff_x  = trial_x - {1'b0, d_in};
    diff_y  = trial_y - {1'b0, d_in};
    ge_x    = trial_x >= {1'b0, d_in};
    ge_y    = trial_y >= {1'b0, d_in};
    rx_nxt  = ge_x ? diff_x[DMW-1:0] : trial_x[DMW-1:0];
    ry_nxt  = ge_y ? diff_y[DMW-1:0] : trial_y[DMW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r    <= d_in;
      rx_r   <= rx_nxt;
      ry_r   <= ry_nxt;
      nx_r   <= {nx_in[NMW-2:0], 1'b0};
      ny_r   <= {ny_in[NMW-2:0], 1'b0};
      qx_r   <= {qx_in[NMW-2:0], ge_x};
      qy_r   <= {qy_in[NMW-2:0], ge_y};
      side_r <= side_in;
    end
  end

  assign vout     = vld_r;
  assign d_out    = d_r;
  assign nx_out   = nx_r;
  assign rx_out   = rx_r;
  assign qx_out   = qx_r;
  assign ny_out   = ny_r;
  assign ry_out   = ry_r;
  assign qy_out   = qy_r;
  assign side_out = side_r;
endmodule

// ----- rtl/segment_intersection_with_margin.sv -----
// An input beat passes the coefficient stages, the divider cells, the sign and output registers.
// Throughput: one beat per cycle; the chain of 3*COORD_BITS+3 divider cells, one quotient
// bit each, holds one item per cell, and the whole pipeline holds while the result waits.
// Reset (rst_n low, synchronous): empties the pipeline and sets margin to 36.
`include "segment_intersection_with_margin_defines.svh"
module segment_intersection_with_margin import si_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  si_in_if.sink                  in_ch,
  si_out_if.source               out_ch,
  input  logic                   cfg_we,
  input  logic [MARGIN_BITS-1:0] cfg_wdata
);
  localparam int N   = COORD_BITS;
  localparam int NMW = 3*N+3;
  localparam int DMW = 2*N+3;
  localparam int FW  = $bits(si_flags_t);
  localparam int SW  = 8*N+FW;
  localparam int QW  = NMW+1;

  logic                   en;
  logic [MARGIN_BITS-1:0] margin_r;

  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      margin_r <= MARGIN_RESET;
    end else if (cfg_we) begin
      margin_r <= cfg_wdata;
    end
  end

  logic           c_vld;
  logic [DMW-1:0] c_den;
  logic [NMW-1:0] c_nx, c_ny;
  si_flags_t      c_flags;
  logic [8*N-1:0] c_bnd;

  si_coef #(.N(N)) u_coef (
    .clk, .rst_n, .en,
    .vin(in_ch.valid && en),
    .ax(in_ch.seg1_start_x), .ay(in_ch.seg1_start_y),
    .bx(in_ch.seg1_end_x),   .by(in_ch.seg1_end_y),
    .cx(in_ch.seg2_start_x), .cy(in_ch.seg2_start_y),
    .dx(in_ch.seg2_end_x),   .dy(in_ch.seg2_end_y),
    .vout(c_vld), .den_mag(c_den), .nx_mag(c_nx), .ny_mag(c_ny),
    .flags(c_flags), .bounds(c_bnd)
  );

  logic           v_c  [NMW+1];
  logic [DMW-1:0] d_c  [NMW+1];
  logic [NMW-1:0] nx_c [NMW+1];
  logic [DMW-1:0] rx_c [NMW+1];
  logic [NMW-1:0] qx_c [NMW+1];
  logic [NMW-1:0] ny_c [NMW+1];
  logic [DMW-1:0] ry_c [NMW+1];
  logic [NMW-1:0] qy_c [NMW+1];
  logic [SW-1:0]  s_c  [NMW+1];

  assign v_c[0]  = c_vld;
  assign d_c[0]  = c_den;
  assign nx_c[0] = c_nx;
  assign ny_c[0] = c_ny;
  assign rx_c[0] = '0;
  assign ry_c[0] = '0;
  assign qx_c[0] = '0;
  assign qy_c[0] = '0;
  assign s_c[0]  = {c_flags, c_bnd};

  for (genvar i = 0; i < NMW; i++) begin : g_cell
    si_div_cell #(.NMW(NMW), .DMW(DMW), .SW(SW)) u_cell (
      .clk, .rst_n, .en,
      .vin(v_c[i]), .d_in(d_c[i]),
      .nx_in(nx_c[i]), .rx_in(rx_c[i]), .qx_in(qx_c[i]),
      .ny_in(ny_c[i]), .ry_in(ry_c[i]), .qy_in(qy_c[i]),
      .side_in(s_c[i]),
      .vout(v_c[i+1]), .d_out(d_c[i+1]),
      .nx_out(nx_c[i+1]), .rx_out(rx_c[i+1]), .qx_out(qx_c[i+1]),
      .ny_out(ny_c[i+1]), .ry_out(ry_c[i+1]), .qy_out(qy_c[i+1]),
      .side_out(s_c[i+1])
    );
  end

  // apply quotient signs
  si_flags_t         fl;
  logic              f1_vld_r;
  logic signed [QW-1:0] xs_r, ys_r;
  logic [SW-1:0]     f1_side_r;

  assign fl = s_c[NMW][SW-1 -: FW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r <= 1'b0;
    end else if (en) begin
      f1_vld_r <= v_c[NMW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xs_r      <= fl.negx ? -$signed({1'b0, qx_c[NMW]}) : $signed({1'b0, qx_c[NMW]});
      ys_r      <= fl.negy ? -$signed({1'b0, qy_c[NMW]}) : $signed({1'b0, qy_c[NMW]});
      f1_side_r <= s_c[NMW];
    end
  end

  // window check
  si_flags_t            fl2;
  logic signed [QW-1:0] lo [8];
  logic signed [QW-1:0] kk;
  logic                 in_win;

  assign fl2 = f1_side_r[SW-1 -: FW];
  assign kk  = $signed({{(QW-MARGIN_BITS){1'b0}}, margin_r});

  always_comb begin
    for (int j = 0; j < 8; j++) begin
      lo[j] = $signed({{(QW-N){1'b0}}, f1_side_r[j*N +: N]});
    end
    in_win = (xs_r >= lo[0] - kk) && (xs_r <= lo[1] + kk) &&
             (xs_r >= lo[2] - kk) && (xs_r <= lo[3] + kk) &&
             (ys_r >= lo[4] - kk) && (ys_r <= lo[5] + kk) &&
             (ys_r >= lo[6] - kk) && (ys_r <= lo[7] + kk);
  end

  logic                       out_valid_r, hit_r;
  logic signed [OUT_BITS-1:0] cross_x_r, cross_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= f1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r     <= fl2.nz && in_win;
      cross_x_r <= (fl2.nz && in_win) ? xs_r[OUT_BITS-1:0] : '0;
      cross_y_r <= (fl2.nz && in_win) ? ys_r[OUT_BITS-1:0] : '0;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.hit     = hit_r;
  assign out_ch.cross_x = cross_x_r;
  assign out_ch.cross_y = cross_y_r;

  `SI_CHK(a_nohit_zero, out_valid_r && !hit_r, cross_x_r == '0 && cross_y_r == '0, "miss beat has nonzero point")
  `SI_CHK(a_hit_range, out_valid_r && hit_r, cross_x_r >= -14'sd256 && cross_y_r >= -14'sd256, "hit point below window")
  `SI_NEXT(a_cfg_write, cfg_we, margin_r == $past(cfg_wdata), "margin write lost")
endmodule

// ----- sim/tb_ifs_note.sv -----
package tb_seg_pkg;
  import si_pkg::*;

  typedef struct packed {
    logic [11:0] ax, ay, bx, by, cx, cy, dx, dy;
  } seg_pair_t;

  typedef struct packed {
    logic                       hit;
    logic signed [OUT_BITS-1:0] cross_x;
    logic signed [OUT_BITS-1:0] cross_y;
  } crossing_t;
endpackage

// ----- sim/tb_crossing_checker.sv -----
module tb_crossing_checker import si_pkg::*; import tb_seg_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  si_in_if                       in_ch,
  si_out_if                      out_ch,
  input  logic                   cfg_we,
  input  logic [MARGIN_BITS-1:0] cfg_wdata,
  output int                     fail_count,
  output int                     pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [MARGIN_BITS-1:0] margin_q;
  crossing_t              crossings_due[$];

  function automatic logic in_box(longint v, longint p, longint q, longint k);
    longint lo, hi;
    lo = (p < q) ? p : q;
    hi = (p < q) ? q : p;
    return (v >= lo - k) && (v <= hi + k);
  endfunction

  function automatic crossing_t solve_crossing(seg_pair_t s, logic [MARGIN_BITS-1:0] m);
    longint ax, ay, bx, by, cx, cy, dx, dy, k;
    longint a1, b1, c1, a2, b2, c2, det, x, y;
    crossing_t r;
    ax = s.ax; ay = s.ay; bx = s.bx; by = s.by;
    cx = s.cx; cy = s.cy; dx = s.dx; dy = s.dy;
    k = m;
    a1 = ay - by; b1 = bx - ax; c1 = ax * by - bx * ay;
    a2 = cy - dy; b2 = dx - cx; c2 = cx * dy - dx * cy;
    det = a1 * b2 - b1 * a2;
    r = '0;
    if (det != 0) begin
      x = -(c1 * b2 - b1 * c2) / det;
      y = -(a1 * c2 - c1 * a2) / det;
      if (in_box(x, ax, bx, k) && in_box(x, cx, dx, k) &&
          in_box(y, ay, by, k) && in_box(y, cy, dy, k)) begin
        r.hit = 1'b1;
        r.cross_x = x[OUT_BITS-1:0];
        r.cross_y = y[OUT_BITS-1:0];
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  initial fail_count = 0;
  assign pending = crossings_due.size();

  always @(posedge clk) begin
    crossing_t e;
    seg_pair_t s;
    if (!rst_n) begin
      margin_q <= MARGIN_RESET;
    end else begin
      if (cfg_we) margin_q <= cfg_wdata;
      if (in_ch.valid && in_ch.ready) begin
        s = {in_ch.seg1_start_x, in_ch.seg1_start_y, in_ch.seg1_end_x, in_ch.seg1_end_y,
             in_ch.seg2_start_x, in_ch.seg2_start_y, in_ch.seg2_end_x, in_ch.seg2_end_y};
        crossings_due = {crossings_due, solve_crossing(s, margin_q)};
      end
      if (out_ch.valid && out_ch.ready) begin
        if (crossings_due.size() == 0) begin
          report_mismatch("unexpected beat", 1, 0);
        end else begin
          e = crossings_due.pop_front();
          if (out_ch.hit !== e.hit) report_mismatch("hit", out_ch.hit, e.hit);
          if (out_ch.cross_x !== e.cross_x) report_mismatch("cross_x", out_ch.cross_x, e.cross_x);
          if (out_ch.cross_y !== e.cross_y) report_mismatch("cross_y", out_ch.cross_y, e.cross_y);
        end
      end
    end
  end
endmodule

// ----- sim/tb_top.sv -----
module tb_top import si_pkg::*; import tb_seg_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 45;
  localparam int STALL_LIMIT = 5000;

  logic                   clk = 0;
  logic                   rst_n = 0;
  logic                   cfg_we = 0;
  logic [MARGIN_BITS-1:0] cfg_wdata = '0;
  int                     fail_count, pending;
  int                     src_idle_pct, snk_idle_pct, quiet_cycles;
  logic                   timed_out = 0;

  si_in_if #(.CB(12)) in_ch ();
  si_out_if           out_ch ();

  segment_intersection_with_margin dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  tb_crossing_checker chk (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .fail_count(fail_count), .pending(pending)
  );

  always #5 clk = ~clk;

  initial begin
    in_ch.valid = 0;
    {in_ch.seg1_start_x, in_ch.seg1_start_y, in_ch.seg1_end_x, in_ch.seg1_end_y,
     in_ch.seg2_start_x, in_ch.seg2_start_y, in_ch.seg2_end_x, in_ch.seg2_end_y} = '0;
    out_ch.ready = 0;
  end

  always @(posedge clk) begin
    if (rst_n) out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    quiet_cycles = 0;
    wait (quiet_cycles >= STALL_LIMIT);
    timed_out = 1;
  end

  task automatic send_pair(seg_pair_t s);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    {in_ch.seg1_start_x, in_ch.seg1_start_y, in_ch.seg1_end_x, in_ch.seg1_end_y,
     in_ch.seg2_start_x, in_ch.seg2_start_y, in_ch.seg2_end_x, in_ch.seg2_end_y} <= s;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic set_margin(logic [MARGIN_BITS-1:0] m);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [11:0] near(logic [11:0] c, int span);
    int v;
    v = int'(c) + $urandom_range(2 * span) - span;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[11:0];
  endfunction

  function automatic seg_pair_t random_pair();
    seg_pair_t s;
    logic [11:0] px, py;
    int span;
    s = {$urandom, $urandom, $urandom};
    case ($urandom_range(9))
      0, 1: ;
      2: begin
        s.cx = s.ax + 12'd7; s.cy = s.ay + 12'd3;
        s.dx = s.bx + 12'd7; s.dy = s.by + 12'd3;
      end
      3: begin
        s.cx = s.ax; s.cy = s.ay;
        s.bx = 12'($urandom); s.by = 12'($urandom);
      end
      default: begin
        span = ($urandom_range(3) == 0) ? 2047 : int'($urandom_range(300, 1));
        px = 12'($urandom); py = 12'($urandom);
        s.ax = near(px, span); s.ay = near(py, span);
        s.bx = near(px, span); s.by = near(py, span);
        s.cx = near(px, span); s.cy = near(py, span);
        s.dx = near(px, span); s.dy = near(py, span);
      end
    endcase
    return s;
  endfunction

  task automatic run_random(int n);
    repeat (n) send_pair(random_pair());
  endtask

  seg_pair_t directed[13];

  initial begin
    src_idle_pct = 0;
    snk_idle_pct = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed[0] = {12'd0, 12'd0, 12'd4095, 12'd4095, 12'd0, 12'd4095, 12'd4095, 12'd0};
    directed[1] = {12'd4095, 12'd4095, 12'd0, 12'd0, 12'd4095, 12'd0, 12'd0, 12'd4095};
    directed[2] = {12'd0, 12'd0, 12'd100, 12'd0, 12'd0, 12'd5, 12'd100, 12'd5};
    directed[3] = {12'd0, 12'd0, 12'd100, 12'd100, 12'd50, 12'd50, 12'd200, 12'd200};
    directed[4] = {12'd10, 12'd10, 12'd10, 12'd10, 12'd0, 12'd0, 12'd50, 12'd20};
    directed[5] = {12'd0, 12'd0, 12'd10, 12'd0, 12'd100, 12'd0, 12'd100, 12'd10};
    directed[6] = {12'd0, 12'd0, 12'd10, 12'd0, 12'd50, 12'd0, 12'd50, 12'd10};
    directed[7] = {12'd0, 12'd0, 12'd0, 12'd4095, 12'd0, 12'd0, 12'd4095, 12'd1};
    directed[8] = {12'd0, 12'd0, 12'd3, 12'd1, 12'd0, 12'd1, 12'd3, 12'd0};
    directed[9] = {12'd0, 12'd0, 12'd4095, 12'd1, 12'd0, 12'd1, 12'd4095, 12'd0};
    directed[10] = {12'd4095, 12'd0, 12'd4094, 12'd4095, 12'd4095, 12'd4095, 12'd0, 12'd4094};
    directed[11] = {12'd0, 12'd4095, 12'd1, 12'd0, 12'd0, 12'd0, 12'd4095, 12'd1};
    directed[12] = {12'd2730, 12'd1365, 12'd1365, 12'd2730, 12'd1365, 12'd1365, 12'd2730,
                    12'd2730};
    foreach (directed[i]) send_pair(directed[i]);

    set_margin(8'd0);
    foreach (directed[i]) send_pair(directed[i]);
    run_random(40);
    set_margin(8'd255);
    foreach (directed[i]) send_pair(directed[i]);
    run_random(40);

    set_margin(8'd5);
    src_idle_pct = 10;
    snk_idle_pct = 80;
    run_random(160);
    drain();
    set_margin(8'd128);
    src_idle_pct = 80;
    snk_idle_pct = 10;
    run_random(160);
    set_margin(8'd36);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    run_random(200);

    drain();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (timed_out) begin
      $display("TEST FAILED");
      $finish;
    end
  end
endmodule
